@@ rtl/core/urmf_pkg.sv @@
// ============================================================================
// urmf_pkg: shared types and constants for the ultrasonic ranger
// Word layouts, register map, controller/datapath command and status bundles.
// ============================================================================
package urmf_pkg;

	// Field widths
	localparam int CAP_W      = 16;
	localparam int INTERVAL_W = 16;
	localparam int SCALE_W    = 21;
	localparam int DIST_W     = 21;
	// Scale product is Q13.8 after dropping 16 fraction bits
	localparam int SCALE_SH   = 16;
	localparam int PROD_W     = CAP_W + SCALE_W;

	// Default filter window length
	localparam int WINDOW_SIZE_DEF = 5;

	// Register port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_INTERVAL  = 2'd0;
	localparam logic [1:0] REG_SCALE     = 2'd1;
	localparam logic [1:0] REG_MIN_VALID = 2'd2;

	// Register reset values
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd100;
	localparam logic [SCALE_W-1:0]    SCALE_RST     = 21'd1150931;
	localparam logic [DIST_W-1:0]     MIN_VALID_RST = 21'd128;

	// Input word opcodes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_CAPTURE = 1'b1;

	// Echo tracking phase
	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_WAIT_RISE = 2'd1,
		PH_WAIT_FALL = 2'd2
	} phase_t;

	// Input word
	typedef struct packed {
		logic              op;
		logic [CAP_W-1:0]  capture_value;
	} evt_t;

	// Result word
	typedef struct packed {
		logic              ping_trigger;
		logic              distance_valid;
		logic [DIST_W-1:0] distance_q8;
		logic              window_done;
		logic [DIST_W-1:0] average_q8;
		logic [DIST_W-1:0] median_q8;
	} res_t;

	// Configuration registers
	typedef struct packed {
		logic [INTERVAL_W-1:0] interval;
		logic [SCALE_W-1:0]    scale;
		logic [DIST_W-1:0]     min_valid;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic exec;
		logic store;
		logic cnt_clr;
		logic sort;
		logic sum;
		logic div_mul;
		logic div_fix;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_fall;
		logic full;
		logic cnt_last;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/urmf_dp.sv @@
// ============================================================================
// urmf_dp: ranger datapath
// Ping timing, echo width scaling, sample window, sort, average and output.
// ============================================================================
module urmf_dp #(
	parameter int WINDOW_SIZE = urmf_pkg::WINDOW_SIZE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  urmf_pkg::evt_t  evt,
	input  urmf_pkg::cfg_t  cfg,
	input  urmf_pkg::cmd_t  cmd,
	input  logic            res_ready,
	output logic            res_valid,
	output urmf_pkg::res_t  res,
	output urmf_pkg::stat_t stat
);

	localparam int IDX_W  = $clog2(WINDOW_SIZE);
	localparam int SUM_W  = urmf_pkg::DIST_W + $clog2(WINDOW_SIZE);
	// Reciprocal precision: 4 guard bits keep the estimate within one of the quotient
	localparam int RCP_SH = SUM_W + 4;
	localparam int DPR_W  = SUM_W + RCP_SH;
	localparam logic [RCP_SH-1:0] RCP      = RCP_SH'((64'd1 << RCP_SH) / WINDOW_SIZE);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_SIZE - 1);
	localparam logic [IDX_W-1:0]  MID_IDX  = IDX_W'(WINDOW_SIZE / 2);
	localparam logic [SUM_W-1:0]  N_SUM    = SUM_W'(WINDOW_SIZE);

	localparam int DIST_W = urmf_pkg::DIST_W;
	localparam int CAP_W  = urmf_pkg::CAP_W;

	// Payload registers
	urmf_pkg::evt_t              evt_q;
	logic [urmf_pkg::PROD_W-1:0] prod_q;
	logic [DIST_W-1:0]           win_q [WINDOW_SIZE];
	logic [SUM_W-1:0]            sum_q;
	logic [SUM_W-1:0]            quo_q;
	urmf_pkg::res_t              res_q;

	// Control state
	urmf_pkg::phase_t  phase_q;
	logic [CAP_W-1:0]  since_q;
	logic [CAP_W-1:0]  start_q;
	logic [IDX_W-1:0]  fill_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [DIST_W-1:0] dist_q;
	logic [DIST_W-1:0] avg_hold_q;
	logic [DIST_W-1:0] med_hold_q;
	logic              trig_q;
	logic              dval_q;
	logic              wdone_q;
	logic              res_valid_q;

	logic [CAP_W-1:0]  since_inc;
	logic              fire;
	logic [CAP_W-1:0]  width;
	logic [DIST_W-1:0] dist_new;
	logic [DIST_W-1:0] win_sorted [WINDOW_SIZE];
	logic [DPR_W-1:0]  div_prod;
	logic [SUM_W-1:0]  rem;
	logic [SUM_W-1:0]  avg_full;
	logic [DIST_W-1:0] avg_new;
	logic [DIST_W-1:0] med_new;

	// Tick: saturating ms count, fire when idle and interval reached
	assign since_inc = (since_q == '1) ? since_q : since_q + CAP_W'(1);
	assign fire      = (phase_q == urmf_pkg::PH_IDLE) && (since_inc >= cfg.interval);

	// Echo width, 16-bit wrap
	assign width    = evt_q.capture_value - start_q;
	assign dist_new = prod_q[urmf_pkg::PROD_W-1:urmf_pkg::SCALE_SH];

	// One odd-even transposition pass; parity from pass count
	always_comb begin
		win_sorted = win_q;
		for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
			if ((1'(i) == cnt_q[0]) && (win_q[i+1] < win_q[i])) begin
				win_sorted[i]   = win_q[i+1];
				win_sorted[i+1] = win_q[i];
			end
		end
	end

	// Average: reciprocal estimate, then one correction step
	assign div_prod = DPR_W'(sum_q) * DPR_W'(RCP);
	assign rem      = sum_q - quo_q * N_SUM;
	assign avg_full = (rem >= N_SUM) ? quo_q + SUM_W'(1) : quo_q;
	assign avg_new  = avg_full[DIST_W-1:0];
	assign med_new  = win_q[MID_IDX];

	// Status
	assign stat.is_fall  = (evt_q.op == urmf_pkg::OP_CAPTURE) &&
	                       (phase_q == urmf_pkg::PH_WAIT_FALL);
	assign stat.full     = (fill_q == LAST_IDX);
	assign stat.cnt_last = (cnt_q == LAST_IDX);
	assign stat.out_free = !res_valid_q || res_ready;

	// Payload path
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			evt_q <= evt;
		end
		if (cmd.exec) begin
			prod_q <= urmf_pkg::PROD_W'(width) * urmf_pkg::PROD_W'(cfg.scale);
		end
		if (cmd.store) begin
			win_q[fill_q] <= dist_new;
		end else if (cmd.sort) begin
			win_q <= win_sorted;
		end
		if (cmd.cnt_clr) begin
			sum_q <= '0;
		end else if (cmd.sum) begin
			sum_q <= sum_q + SUM_W'(win_q[cnt_q]);
		end
		if (cmd.div_mul) begin
			quo_q <= div_prod[DPR_W-1:RCP_SH];
		end
		if (cmd.emit) begin
			res_q.ping_trigger   <= trig_q;
			res_q.distance_valid <= dval_q;
			res_q.distance_q8    <= dist_q;
			res_q.window_done    <= wdone_q;
			res_q.average_q8     <= avg_hold_q;
			res_q.median_q8      <= med_hold_q;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= urmf_pkg::PH_IDLE;
			since_q     <= '0;
			start_q     <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			dist_q      <= '0;
			avg_hold_q  <= '0;
			med_hold_q  <= '0;
			trig_q      <= 1'b0;
			dval_q      <= 1'b0;
			wdone_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// New word clears event flags
			if (cmd.load_in) begin
				trig_q  <= 1'b0;
				dval_q  <= 1'b0;
				wdone_q <= 1'b0;
			end

			// Step the echo tracker
			if (cmd.exec) begin
				if (evt_q.op == urmf_pkg::OP_TICK) begin
					if (fire) begin
						since_q <= '0;
						trig_q  <= 1'b1;
						phase_q <= urmf_pkg::PH_WAIT_RISE;
					end else begin
						since_q <= since_inc;
					end
				end else if (phase_q == urmf_pkg::PH_WAIT_RISE) begin
					start_q <= evt_q.capture_value;
					phase_q <= urmf_pkg::PH_WAIT_FALL;
				end else if (phase_q == urmf_pkg::PH_WAIT_FALL) begin
					dval_q  <= 1'b1;
					phase_q <= urmf_pkg::PH_IDLE;
				end
			end

			// Record sample and advance fill
			if (cmd.store) begin
				dist_q <= dist_new;
				fill_q <= stat.full ? '0 : fill_q + IDX_W'(1);
			end

			// Pass / element counter
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.sort || cmd.sum) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end

			// Keep statistics above threshold
			if (cmd.div_fix) begin
				wdone_q <= 1'b1;
				if (avg_new > cfg.min_valid) begin
					avg_hold_q <= avg_new;
				end
				if (med_new > cfg.min_valid) begin
					med_hold_q <= med_new;
				end
			end

			// Output register
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	// Completing a window wraps the fill index
	a_fill_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store && stat.full |=> fill_q == '0)
		else $error("fill index did not wrap after full window");

	// A trigger always arms the echo wait
	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (evt_q.op == urmf_pkg::OP_TICK) && fire
		|=> phase_q == urmf_pkg::PH_WAIT_RISE && trig_q)
		else $error("trigger without rise wait");

	// Reciprocal estimate is off by at most one
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_fix |-> rem < (N_SUM + N_SUM))
		else $error("average quotient estimate out of range");
`endif

endmodule

@@ rtl/core/urmf_ctrl.sv @@
// ============================================================================
// urmf_ctrl: ranger sequencer
// One-hot state machine that steps the datapath through each input word.
// ============================================================================
module urmf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	output logic            evt_ready,
	input  urmf_pkg::stat_t stat,
	output urmf_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_STORE = 8'b0000_0100,
		S_SORT  = 8'b0000_1000,
		S_SUM   = 8'b0001_0000,
		S_DIVM  = 8'b0010_0000,
		S_DIVF  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign evt_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (evt_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.is_fall ? S_STORE : S_EMIT;
			end
			S_STORE: begin
				cmd.store = 1'b1;
				if (stat.full) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_SORT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_SORT: begin
				cmd.sort = 1'b1;
				if (stat.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				if (stat.cnt_last) begin
					state_d = S_DIVM;
				end
			end
			S_DIVM: begin
				cmd.div_mul = 1'b1;
				state_d     = S_DIVF;
			end
			S_DIVF: begin
				cmd.div_fix = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	// An accepted word is executed next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> state_q == S_EXEC)
		else $error("accepted word not executed");

	// Loading the output ends the word
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE && evt_ready)
		else $error("not idle after emit");

	// Correction always follows the reciprocal multiply
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIVF |-> $past(state_q) == S_DIVM)
		else $error("divide steps out of order");
`endif

endmodule

@@ rtl/core/ultrasonic_ranger_median_filter.sv @@
// ============================================================================
// ultrasonic_ranger_median_filter: echo ranger with windowed median filter
// Register file, sequencer and datapath of the ultrasonic ranging block.
// ============================================================================
// Usage:
//   evt channel (valid/ready) takes one word per event: op = 0 for a 1 ms
//   tick, op = 1 for an echo edge with the captured timer count.
//   res channel (valid/ready) returns exactly one word per input word:
//   trigger request, new distance, window completion and held statistics.
//   Registers (APB, 0x0 interval ms, 0x4 scale, 0x8 threshold) must be
//   written only while the block is idle; the block does not enforce this.
// Timing:
//   Ticks, rising edges and stray captures pass from the execute state to the
//   emit state, which loads the output register; a falling edge that does not
//   fill the window also passes the store state. A falling edge that fills the
//   window then sorts (one sort pass per cycle), sums one window entry per
//   cycle and runs a two-step reciprocal divide before the emit state.
//   One word is in work at a time; evt_ready returns the cycle after the
//   result is loaded into the output register.
// Reset and stall:
//   Reset restores register defaults and clears timing, phase, fill and held
//   values. A stalled res_ready holds the result word; the next input word is
//   still accepted and processed, then waits until the output register frees.
// ============================================================================
module ultrasonic_ranger_median_filter #(
	parameter int WINDOW_SIZE = urmf_pkg::WINDOW_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [urmf_pkg::ADDR_W-1:0] paddr,
	input  logic [urmf_pkg::DATA_W-1:0] pwdata,
	output logic [urmf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// Event words
	input  logic                        evt_valid,
	output logic                        evt_ready,
	input  urmf_pkg::evt_t              evt,
	// Result words
	output logic                        res_valid,
	input  logic                        res_ready,
	output urmf_pkg::res_t              res
);

	urmf_pkg::cfg_t  cfg_q;
	urmf_pkg::cmd_t  cmd;
	urmf_pkg::stat_t stat;
	logic            wr_en;
	logic [1:0]      reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval  <= urmf_pkg::INTERVAL_RST;
			cfg_q.scale     <= urmf_pkg::SCALE_RST;
			cfg_q.min_valid <= urmf_pkg::MIN_VALID_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				urmf_pkg::REG_INTERVAL:  cfg_q.interval  <= pwdata[urmf_pkg::INTERVAL_W-1:0];
				urmf_pkg::REG_SCALE:     cfg_q.scale     <= pwdata[urmf_pkg::SCALE_W-1:0];
				urmf_pkg::REG_MIN_VALID: cfg_q.min_valid <= pwdata[urmf_pkg::DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			urmf_pkg::REG_INTERVAL:  prdata = urmf_pkg::DATA_W'(cfg_q.interval);
			urmf_pkg::REG_SCALE:     prdata = urmf_pkg::DATA_W'(cfg_q.scale);
			urmf_pkg::REG_MIN_VALID: prdata = urmf_pkg::DATA_W'(cfg_q.min_valid);
			default:                 prdata = '0;
		endcase
	end

	urmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	urmf_dp #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.stat      (stat)
	);

endmodule

@@ sim/urmf_ranging_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// urmf_ranging_checker: result predictor and scoreboard for the ranger
// Watches the register port and both word channels, tracks the ranging state
// (ping count, echo phase, sample window, held statistics) and compares every
// result word field by field with the oldest predicted word.
// ============================================================================
module urmf_ranging_checker
	import urmf_pkg::*;
#(
	parameter int WIN = WINDOW_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              evt_valid,
	input  logic              evt_ready,
	input  evt_t              evt,
	input  logic              res_valid,
	input  logic              res_ready,
	input  res_t              res,
	output int                mismatches,
	output int                outstanding
);

	// Register copies
	logic [INTERVAL_W-1:0] cfg_interval;
	logic [SCALE_W-1:0]    cfg_scale;
	logic [DIST_W-1:0]     cfg_min_valid;

	// Ranging state
	phase_t                echo_phase;
	logic [INTERVAL_W-1:0] ms_since_ping;
	logic [CAP_W-1:0]      rise_stamp;
	logic [DIST_W-1:0]     samples [WIN];
	logic [3:0]            n_samples;
	logic [DIST_W-1:0]     avg_kept;
	logic [DIST_W-1:0]     median_kept;
	logic [DIST_W-1:0]     last_dist;

	res_t expected_words[$];
	int   errs;

	// Advance the ranging state by one event word and return the result word
	function automatic res_t advance_ranger(evt_t w);
		res_t                 r;
		logic [CAP_W-1:0]     pulse;
		logic [PROD_W-1:0]    prod;
		logic [DIST_W+3:0]    total;
		logic [DIST_W-1:0]    mean;
		logic [DIST_W-1:0]    mid;
		logic [DIST_W-1:0]    tmp;
		r = '0;
		if (w.op == OP_TICK) begin
			// count saturates, and keeps running while an echo is pending
			if (ms_since_ping != '1)
				ms_since_ping++;
			if (echo_phase == PH_IDLE && ms_since_ping >= cfg_interval) begin
				r.ping_trigger = 1'b1;
				ms_since_ping = '0;
				echo_phase = PH_WAIT_RISE;
			end
		end else if (echo_phase == PH_WAIT_RISE) begin
			rise_stamp = w.capture_value;
			echo_phase = PH_WAIT_FALL;
		end else if (echo_phase == PH_WAIT_FALL) begin
			// width wraps mod 2^16; product >> 16 always fits 21 bits
			pulse = w.capture_value - rise_stamp;
			prod = PROD_W'(pulse) * PROD_W'(cfg_scale);
			last_dist = prod[SCALE_SH +: DIST_W];
			r.distance_valid = 1'b1;
			echo_phase = PH_IDLE;
			samples[n_samples] = last_dist;
			n_samples++;
			if (n_samples == WIN) begin
				n_samples = '0;
				for (int i = 0; i < WIN; i++)
					for (int j = i + 1; j < WIN; j++)
						if (samples[j] < samples[i]) begin
							tmp = samples[i];
							samples[i] = samples[j];
							samples[j] = tmp;
						end
				total = '0;
				for (int i = 0; i < WIN; i++)
					total += samples[i];
				mean = DIST_W'(total / WIN);
				mid = samples[WIN / 2];
				// strictly greater keeps; otherwise hold the old value
				if (mean > cfg_min_valid)
					avg_kept = mean;
				if (mid > cfg_min_valid)
					median_kept = mid;
				r.window_done = 1'b1;
			end
		end
		r.distance_q8 = last_dist;
		r.average_q8 = avg_kept;
		r.median_q8 = median_kept;
		return r;
	endfunction

	task automatic check_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endtask

	// Register writes, result compare, event prediction
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			cfg_interval = INTERVAL_RST;
			cfg_scale = SCALE_RST;
			cfg_min_valid = MIN_VALID_RST;
			echo_phase = PH_IDLE;
			ms_since_ping = '0;
			rise_stamp = '0;
			n_samples = '0;
			avg_kept = '0;
			median_kept = '0;
			last_dist = '0;
			expected_words.delete();
			errs = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_INTERVAL:  cfg_interval = pwdata[INTERVAL_W-1:0];
					REG_SCALE:     cfg_scale = pwdata[SCALE_W-1:0];
					REG_MIN_VALID: cfg_min_valid = pwdata[DIST_W-1:0];
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with no event word pending");
					errs++;
				end else begin
					want = expected_words.pop_front();
					check_field("ping_trigger", want.ping_trigger, res.ping_trigger);
					check_field("distance_valid", want.distance_valid, res.distance_valid);
					check_field("distance_q8", want.distance_q8, res.distance_q8);
					check_field("window_done", want.window_done, res.window_done);
					check_field("average_q8", want.average_q8, res.average_q8);
					check_field("median_q8", want.median_q8, res.median_q8);
				end
			end
			if (evt_valid && evt_ready)
				expected_words.push_back(advance_ranger(evt));
		end
		mismatches <= errs;
		outstanding <= expected_words.size();
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench: ultrasonic ranger with median filter
// Runs the first ping and one echo at reset settings, a short list of edge
// cases, then random ping/echo sequences under several register settings,
// with random gaps on both channels and one long result stall.
// ============================================================================
module testbench;
	import urmf_pkg::*;

	localparam int BULK_WORDS      = int'(INTERVAL_RST) + 3;
	localparam int DIRECTED_WORDS  = 16;
	localparam int STALL_AT        = BULK_WORDS + DIRECTED_WORDS + 120;
	localparam int STALL_CYCLES    = 400;
	localparam int RANDOM_PHASES   = 6;
	localparam int WORDS_PER_PHASE = 70;
	localparam int SETTLE_CYCLES   = 2 * WINDOW_SIZE_DEF + 10;
	localparam int CYCLE_LIMIT     = 200_000;

	localparam logic [1:0]            REG_SPARE     = 2'd3;
	localparam logic [INTERVAL_W-1:0] INTERVAL_MAX  = '1;
	localparam logic [SCALE_W-1:0]    SCALE_MAX     = '1;
	localparam logic [DIST_W-1:0]     MIN_VALID_MAX = '1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              evt_valid;
	logic              evt_ready;
	evt_t              evt;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	int                mismatches;
	int                outstanding;

	bit                    pace_on;
	int                    words_sent;
	int                    results_taken;
	int                    cycle_count;
	logic [INTERVAL_W-1:0] cur_interval;

	ultrasonic_ranger_median_filter u_top (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.evt_valid, .evt_ready, .evt,
		.res_valid, .res_ready, .res
	);

	urmf_ranging_checker u_checker (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.evt_valid, .evt_ready, .evt,
		.res_valid, .res_ready, .res,
		.mismatches, .outstanding
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one event word after a random gap, hold it until taken
	task automatic send_word(input logic op, input logic [CAP_W-1:0] cap);
		int gap;
		gap = pace_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt.op <= op;
		evt.capture_value <= cap;
		@(posedge clk);
		while (!(evt_valid && evt_ready)) @(posedge clk);
		words_sent++;
	endtask

	// Stop offering and let every pending result drain
	task automatic wait_idle();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup then access phase; register is written on the access edge
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Upper data bits are junk; the block keeps only the field width
	task automatic set_ranging(input logic [INTERVAL_W-1:0] interval,
			input logic [SCALE_W-1:0] scale, input logic [DIST_W-1:0] min_valid);
		write_reg(REG_INTERVAL, {16'($urandom), interval});
		write_reg(REG_SCALE, {11'($urandom), scale});
		write_reg(REG_MIN_VALID, {11'($urandom), min_valid});
		cur_interval = interval;
	endtask

	// Result side: random stalls, one long hold-off to back up the block
	initial begin
		int stall;
		res_ready <= 1'b0;
		results_taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_taken == STALL_AT)
				stall = STALL_CYCLES;
			else
				stall = pace_on ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!(res_valid && res_ready)) @(posedge clk);
			results_taken++;
		end
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Event side and verdict
	initial begin
		int               phase_end;
		int               ticks;
		logic [CAP_W-1:0] rise;
		logic [CAP_W-1:0] pulse;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		evt_valid <= 1'b0;
		evt <= '0;
		pace_on = 1'b0;
		words_sent = 0;
		cur_interval = INTERVAL_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first ping and one echo
		repeat (INTERVAL_RST) send_word(OP_TICK, 16'($urandom));
		send_word(OP_CAPTURE, 16'h0100);
		send_word(OP_CAPTURE, 16'h0a00);
		wait_idle();
		// a fresh count stays below the largest interval
		write_reg(REG_INTERVAL, {16'($urandom), INTERVAL_MAX});
		send_word(OP_TICK, 16'($urandom));
		wait_idle();

		// Edge cases: a wrapped width, zero width, stray capture
		set_ranging('0, SCALE_MAX, '0);
		pace_on = 1'b1;
		send_word(OP_CAPTURE, 16'hffff);
		send_word(OP_TICK, 16'h0000);
		send_word(OP_CAPTURE, 16'h0000);
		send_word(OP_CAPTURE, 16'habcd);
		send_word(OP_TICK, 16'hffff);
		send_word(OP_CAPTURE, 16'h0000);
		send_word(OP_CAPTURE, 16'hffff);
		send_word(OP_TICK, 16'h5555);
		send_word(OP_CAPTURE, 16'h1234);
		send_word(OP_CAPTURE, 16'h1234);
		send_word(OP_TICK, 16'haaaa);
		send_word(OP_CAPTURE, 16'h8000);
		send_word(OP_CAPTURE, 16'h7fff);
		send_word(OP_TICK, 16'h0f0f);
		send_word(OP_CAPTURE, 16'h0001);
		send_word(OP_CAPTURE, 16'hfffe);

		// Random ping/echo traffic under several settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: set_ranging(16'd3, SCALE_MAX, '0);
				1: begin
					set_ranging(16'd1, '0, MIN_VALID_MAX);
					write_reg(REG_SPARE, $urandom);
				end
				2: set_ranging(16'd2, SCALE_RST, MIN_VALID_RST);
				default: set_ranging(16'($urandom_range(0, 4)),
					21'($urandom_range(0, SCALE_MAX)), 21'($urandom_range(0, 80000)));
			endcase
			phase_end = words_sent + WORDS_PER_PHASE;
			while (words_sent < phase_end) begin
				pace_on = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 6) == 0) begin
					// noise: random words that may break the echo sequence
					repeat ($urandom_range(1, 3))
						send_word(1'($urandom), 16'($urandom));
				end else begin
					ticks = (cur_interval == 0 ? 1 : int'(cur_interval)) + $urandom_range(0, 1);
					repeat (ticks) send_word(OP_TICK, 16'($urandom));
					rise = 16'($urandom);
					send_word(OP_CAPTURE, rise);
					if ($urandom_range(0, 4) == 0)
						send_word(OP_TICK, 16'($urandom));
					pulse = ($urandom_range(0, 7) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 4000));
					send_word(OP_CAPTURE, rise + pulse);
				end
			end
		end

		wait_idle();
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/urmf_pkg.sv
rtl/core/urmf_dp.sv
rtl/core/urmf_ctrl.sv
rtl/core/ultrasonic_ranger_median_filter.sv
sim/urmf_ranging_checker.sv
sim/testbench.sv
